// ===== src/char_lcd_text_writer_defines.svh =====
// Assertion macros for the character LCD text writer bus sequencer.
`ifndef CHAR_LCD_TEXT_WRITER_DEFINES_SVH
`define CHAR_LCD_TEXT_WRITER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CLW_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clw same-cycle check failed");
`define CLW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clw next-cycle check failed");
`else
`define CLW_ASSERT_SAME(label, ante, cons)
`define CLW_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== src/clw_pkg.sv =====
// Types, codes and topology tables for the character LCD text writer.
`timescale 1ns / 1ps
package clw_pkg;

    typedef enum logic [1:0] {
        OP_PRINT      = 2'd0,
        OP_SET_CURSOR = 2'd1,
        OP_HOME       = 2'd2,
        OP_CLEAR      = 2'd3
    } op_t;

    localparam logic [7:0] CH_NULL      = 8'h00;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;

    localparam logic [7:0] DDRAM_SET = 8'h80;
    localparam logic [7:0] CMD_HOME  = 8'h02;
    localparam logic [7:0] CMD_CLEAR = 8'h01;

    localparam logic [2:0] TOPOLOGY_RESET = 3'd4;

    localparam logic [2:0] REG_TOPOLOGY  = 3'd0;
    localparam logic [2:0] REG_BACKLIGHT = 3'd4;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] char_code;
        logic [7:0] target_column;
        logic [7:0] target_row;
    } clw_in_t;

    typedef struct packed {
        logic [7:0] bus_byte;
        logic       last;
        logic [6:0] cursor_position;
    } clw_out_t;

    // One queued job: one or two LCD bytes plus the cursor position to report
    typedef struct packed {
        logic       two_bytes;
        logic [7:0] cmd_byte;
        logic [7:0] data_byte;
        logic [6:0] cursor_position;
    } clw_job_t;

    function automatic logic [5:0] topo_cols(input logic [2:0] t);
        case (t)
            3'd0:    topo_cols = 6'd40;
            3'd1:    topo_cols = 6'd20;
            3'd2:    topo_cols = 6'd20;
            3'd7:    topo_cols = 6'd8;
            default: topo_cols = 6'd16;
        endcase
    endfunction

    function automatic logic [2:0] topo_rows(input logic [2:0] t);
        case (t)
            3'd1:    topo_rows = 3'd4;
            3'd3:    topo_rows = 3'd4;
            3'd5:    topo_rows = 3'd1;
            3'd6:    topo_rows = 3'd1;
            default: topo_rows = 3'd2;
        endcase
    endfunction

    function automatic logic [7:0] row_base(input logic [2:0] t, input logic [1:0] r);
        logic [7:0] base;
        base = 8'h00;
        case (t)
            3'd1:
            begin
                case (r)
                    2'd1:    base = 8'h40;
                    2'd2:    base = 8'h14;
                    2'd3:    base = 8'h54;
                    default: base = 8'h00;
                endcase
            end
            3'd3:
            begin
                case (r)
                    2'd1:    base = 8'h40;
                    2'd2:    base = 8'h10;
                    2'd3:    base = 8'h50;
                    default: base = 8'h00;
                endcase
            end
            3'd6:    base = 8'h00;
            3'd7:    base = (r[0]) ? 8'h40 : 8'h00;
            default: base = (r == 2'd1) ? 8'h40 : 8'h00;
        endcase
        return base;
    endfunction

    // Column after increment, wrapped at the column count; x is at most 64
    function automatic logic [5:0] col_wrap(input logic [6:0] x, input logic [5:0] cols);
        logic [6:0] r;
        r = x;
        case (cols)
            6'd40:
            begin
                if (x >= 7'd40)
                    r = x - 7'd40;
            end
            6'd20:
            begin
                if (x >= 7'd60)
                    r = x - 7'd60;
                else if (x >= 7'd40)
                    r = x - 7'd40;
                else if (x >= 7'd20)
                    r = x - 7'd20;
            end
            6'd16:   r = x & 7'd15;
            6'd8:    r = x & 7'd7;
            default: r = x;
        endcase
        return r[5:0];
    endfunction

endpackage

// ===== src/char_lcd_text_writer.sv =====
// Top level of the character LCD text writer: config registers and the three stages.
// Usage:
//   in_valid/in_stall/in_data carry one command beat (print, set cursor, home, clear).
//   out_valid/out_stall/out_data carry expander beats: bus_byte, last, cursor_position.
//   A beat moves on a rising edge where valid is high and stall is low.
//   A printable character gives 12 beats (DDRAM address, then data); set cursor,
//   home and clear give 6; null gives none, and newline, return and backspace give
//   none and only move the cursor. The last beat of each command has last set.
// Path: a taken command is queued; its first beat is then registered onto out_valid.
// Throughput: one beat per cycle while out_stall is low, set by the bus sequencer;
//   the decoder takes new commands while the sequencer works, until the queue
//   holds QUEUE_DEPTH jobs, counting the one being sequenced.
// Reset: cursor goes to 0,0, topology to 16x2, backlight off, queue and outputs empty.
// Stall: an out_stall holds the current beat; once the queue fills, in_stall rises.
// Config: APB, topology at 0x0, backlight_on at 0x4; write only while idle.
`timescale 1ns / 1ps
module char_lcd_text_writer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  logic             in_valid,
    output logic             in_stall,
    input  clw_pkg::clw_in_t in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output clw_pkg::clw_out_t out_data
);
    import clw_pkg::*;

    logic [2:0] topology_reg;
    logic       backlight_reg;
    logic       cfg_write;
    logic       queue_full;
    logic       push;
    clw_job_t   push_job;
    logic       pop;
    logic       head_valid;
    clw_job_t   head_job;

    // Config port: always ready, decode on bit 2 of the byte address
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            topology_reg  <= TOPOLOGY_RESET;
            backlight_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            if ({paddr[2], 2'b00} == REG_BACKLIGHT)
                backlight_reg <= pwdata[0];
            else
                topology_reg <= pwdata[2:0];
        end
    end

    always_comb
    begin
        if ({paddr[2], 2'b00} == REG_BACKLIGHT)
            prdata = {31'd0, backlight_reg};
        else
            prdata = {29'd0, topology_reg};
    end

    // Decoder: update the cursor and queue the LCD bytes for each command
    clw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .topology   (topology_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    // Decouple the decoder from the slower bus sequencer
    clw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Sequencer: three writes per nibble, high nibble first, one beat per cycle unless out_stall holds it
    clw_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .backlight_on (backlight_reg),
        .head_valid   (head_valid),
        .head_job     (head_job),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data)
    );

endmodule

// ===== src/clw_front.sv =====
// Command decoder: keeps the cursor and turns each command into an LCD byte job.
`timescale 1ns / 1ps
module clw_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [2:0]        topology,
    input  logic              in_valid,
    output logic              in_stall,
    input  clw_pkg::clw_in_t  in_data,
    input  logic              queue_full,
    output logic              push,
    output clw_pkg::clw_job_t push_job
);
    import clw_pkg::*;

    logic [5:0] col_reg, col_next;
    logic [1:0] row_reg, row_next;
    logic       accept;
    logic [5:0] cols;
    logic [2:0] rows;
    logic [1:0] row_inc;
    logic [5:0] col_inc;
    logic [7:0] addr_old;
    logic [7:0] addr_new;
    logic [7:0] pos_full;
    logic       emits;

    assign in_stall = queue_full;
    assign accept   = in_valid && !in_stall;
    assign cols     = topo_cols(topology);
    assign rows     = topo_rows(topology);

    always_comb
    begin
        logic [2:0] row_plus;
        row_plus = {1'b0, row_reg} + 3'd1;
        row_inc  = 2'(row_plus & (rows - 3'd1));
        col_inc  = col_wrap({1'b0, col_reg} + 7'd1, cols);
        addr_old = DDRAM_SET | (row_base(topology, row_reg) + {2'b00, col_reg});
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        emits    = 1'b0;
        addr_new = DDRAM_SET;
        push_job.two_bytes = 1'b0;
        push_job.cmd_byte  = CMD_CLEAR;
        push_job.data_byte = in_data.char_code;
        case (in_data.opcode)
            OP_PRINT:
            begin
                if (in_data.char_code == CH_NEWLINE || in_data.char_code == CH_RETURN)
                begin
                    col_next = 6'd0;
                    row_next = row_inc;
                end
                else if (in_data.char_code == CH_BACKSPACE)
                begin
                    if (col_reg != 6'd0)
                        col_next = col_reg - 6'd1;
                end
                else if (in_data.char_code != CH_NULL)
                begin
                    emits = 1'b1;
                    push_job.two_bytes = 1'b1;
                    push_job.cmd_byte  = addr_old;
                    col_next = col_inc;
                    if (col_inc == 6'd0)
                        row_next = row_inc;
                end
            end
            OP_SET_CURSOR:
            begin
                emits = 1'b1;
                col_next = (in_data.target_column >= {2'b00, cols}) ? 6'd0
                                                                  : in_data.target_column[5:0];
                row_next = (in_data.target_row >= {5'b0, rows}) ? 2'd0
                                                              : in_data.target_row[1:0];
                addr_new = DDRAM_SET | (row_base(topology, row_next) + {2'b00, col_next});
                push_job.cmd_byte = addr_new;
            end
            OP_HOME:
            begin
                emits = 1'b1;
                col_next = 6'd0;
                row_next = 2'd0;
                push_job.cmd_byte = CMD_HOME;
            end
            OP_CLEAR:
            begin
                emits = 1'b1;
                push_job.cmd_byte = CMD_CLEAR;
            end
            default:
            begin
                emits = 1'b0;
            end
        endcase
        pos_full = {2'b00, col_next} + (8'(row_next) * 8'(cols));
        push_job.cursor_position = pos_full[6:0];
    end

    assign push = accept && emits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= 6'd0;
            row_reg <= 2'd0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== src/clw_queue.sv =====
// Short FIFO of LCD byte jobs between the decoder and the bus sequencer.
`timescale 1ns / 1ps
module clw_queue #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  clw_pkg::clw_job_t push_job,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output clw_pkg::clw_job_t head_job
);
    import clw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    clw_job_t           entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== src/clw_back.sv =====
// Bus sequencer: expands each LCD byte into six expander beats.
`timescale 1ns / 1ps
`include "char_lcd_text_writer_defines.svh"
module clw_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              backlight_on,
    input  logic              head_valid,
    input  clw_pkg::clw_job_t head_job,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output clw_pkg::clw_out_t out_data
);
    import clw_pkg::*;

    logic       byte_sel_reg, byte_sel_next;
    logic       nib_sel_reg, nib_sel_next;
    logic [1:0] phase_reg, phase_next;
    logic       valid_reg, valid_next;
    clw_out_t   data_reg;
    clw_out_t   beat;
    logic       advance;
    logic       fire;
    logic       final_beat;
    logic [7:0] cur_byte;
    logic [3:0] nibble;

    assign advance    = !valid_reg || !out_stall;
    assign fire       = head_valid && advance;
    assign final_beat = (phase_reg == 2'd2) && nib_sel_reg
                        && (byte_sel_reg || !head_job.two_bytes);
    assign pop        = fire && final_beat;

    assign cur_byte = byte_sel_reg ? head_job.data_byte : head_job.cmd_byte;
    assign nibble   = nib_sel_reg ? cur_byte[3:0] : cur_byte[7:4];

    always_comb
    begin
        beat.bus_byte        = {nibble, backlight_on, (phase_reg == 2'd1), 1'b0, byte_sel_reg};
        beat.last            = final_beat;
        beat.cursor_position = head_job.cursor_position;
    end

    always_comb
    begin
        byte_sel_next = byte_sel_reg;
        nib_sel_next  = nib_sel_reg;
        phase_next    = phase_reg;
        if (fire)
        begin
            if (phase_reg == 2'd2)
            begin
                phase_next = 2'd0;
                if (final_beat)
                begin
                    byte_sel_next = 1'b0;
                    nib_sel_next  = 1'b0;
                end
                else if (nib_sel_reg)
                begin
                    nib_sel_next  = 1'b0;
                    byte_sel_next = 1'b1;
                end
                else
                    nib_sel_next = 1'b1;
            end
            else
                phase_next = phase_reg + 2'd1;
        end
        if (fire)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_sel_reg <= 1'b0;
            nib_sel_reg  <= 1'b0;
            phase_reg    <= 2'd0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            byte_sel_reg <= byte_sel_next;
            nib_sel_reg  <= nib_sel_next;
            phase_reg    <= phase_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            data_reg <= beat;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    `CLW_ASSERT_SAME(a_pop_needs_job, pop, head_valid)
    `CLW_ASSERT_SAME(a_last_has_en_low, valid_reg && data_reg.last, !data_reg.bus_byte[2])
    `CLW_ASSERT_NEXT(a_pop_restarts_seq, pop, phase_reg == 2'd0 && !nib_sel_reg && !byte_sel_reg)
    `CLW_ASSERT_NEXT(a_stall_holds_beat, valid_reg && out_stall, valid_reg && $stable(data_reg))

endmodule
